/* hw/rtl/rtks_pkg.sv */
// ----------------------------------------------------------------------------
// rtks_pkg: shared types and constants of the ranked top-k selector
// Field widths, register and status codes, controller command and status words.
// ----------------------------------------------------------------------------
package rtks_pkg;

  localparam int unsigned ID_W       = 64;
  localparam int unsigned RANK_W     = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned DIV_W      = VAL_W + 1;
  localparam int unsigned DC_W       = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DESIRED_COUNT = 3'd0,
    REG_HUNGER_LOW    = 3'd1,
    REG_HUNGER_HIGH   = 3'd2,
    REG_THREAT_LOW    = 3'd3,
    REG_THREAT_HIGH   = 3'd4
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SHORT = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    scan_init;
    logic    scan_rd;
    logic    scan_again;
    logic    pick_commit;
    logic    mod_start;
    logic    emit_pick;
    logic    emit_status;
    status_t status_code;
    logic    set_clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic want_zero;
    logic scan_last;
    logic found;
    logic pick_last;
    logic mod_done;
    logic out_free;
    logic out_last;
  } sts_t;

endpackage

/* hw/rtl/rtks_if.sv */
// ----------------------------------------------------------------------------
// rtks_if: stream channels of the ranked top-k selector
// Candidate channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface rtks_cand_if;
  import rtks_pkg::*;

  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   cand_id;
  logic [RANK_W-1:0] cand_rank;
  logic              last_candidate;

  modport source (output valid, output cand_id, output cand_rank, output last_candidate,
                  input ready);
  modport sink   (input valid, input cand_id, input cand_rank, input last_candidate,
                  output ready);
endinterface

interface rtks_res_if;
  import rtks_pkg::*;

  logic                valid;
  logic                ready;
  logic [ID_W-1:0]     picked_id;
  logic [VAL_W-1:0]    hunger_value;
  logic [VAL_W-1:0]    threat_value;
  logic [STATUS_W-1:0] status;
  logic                last_result;

  modport source (output valid, output picked_id, output hunger_value, output threat_value,
                  output status, output last_result, input ready);
  modport sink   (input valid, input picked_id, input hunger_value, input threat_value,
                  input status, input last_result, output ready);
endinterface

/* hw/rtl/ranked_top_k_select_spread_top.sv */
// ----------------------------------------------------------------------------
// ranked_top_k_select_spread_top: ranked top-k selector with spread values
// Collects (id, rank) candidates, picks distinct ids, emits them with spreads.
// ----------------------------------------------------------------------------
// Candidate words load at one per cycle into the candidate memory; a word that
// arrives once MAX_CANDIDATES entries are held is dropped, but a dropped word
// still closes the set when it carries last_candidate. On the closing word the
// block stops taking candidates and runs one scan over the N stored entries
// per pick, keeping the best by rank (higher first, lower id on a tie); each
// scan reads the stored entries through the single read port of the candidate
// memory, and marks every entry whose id matches the previous pick so that
// duplicates drop out. Once all picks are found, the two spread values of
// each result come from a pair of bit-serial remainder units that retire
// one dividend bit per cycle over the 64-bit id. A requested count
// of zero gives one status word (1); fewer distinct ids than requested give
// one status word (2); the requested count saturates at MAX_PICK. The result
// stage is registered, so a new set may start loading while the final word of
// the previous set waits to be taken. The user must write the configuration
// registers only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module ranked_top_k_select_spread_top #(
  parameter int unsigned MAX_CANDIDATES = 256,
  parameter int unsigned MAX_PICK       = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rtks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtks_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  rtks_cand_if.sink                       cand,
  rtks_res_if.source                      res
);
  import rtks_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accepts candidate words, steps scans and emission
  rtks_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cand_valid (cand.valid),
    .cand_last  (cand.last_candidate),
    .cand_ready (cand.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: memories, compare, remainder units and the result register
  rtks_dp #(
    .MAX_CANDIDATES (MAX_CANDIDATES),
    .MAX_PICK       (MAX_PICK)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wr_data  (cfg_wr_data),
    .cand_id      (cand.cand_id),
    .cand_rank    (cand.cand_rank),
    .cmd          (cmd),
    .sts          (sts),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .picked_id    (res.picked_id),
    .hunger_value (res.hunger_value),
    .threat_value (res.threat_value),
    .status       (res.status),
    .last_result  (res.last_result)
  );

endmodule

/* hw/rtl/rtks_ram.sv */
// ----------------------------------------------------------------------------
// rtks_ram: generic single-write, single-read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rtks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/rtks_mod.sv */
// ----------------------------------------------------------------------------
// rtks_mod: iterative remainder unit
// Restoring division of a 64-bit id by a 33-bit modulus, one bit per cycle.
// ----------------------------------------------------------------------------
module rtks_mod (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rtks_pkg::ID_W-1:0]  dividend,
  input  logic [rtks_pkg::DIV_W-1:0] divisor,
  output logic                       busy,
  output logic [rtks_pkg::VAL_W-1:0] rem
);
  import rtks_pkg::*;

  localparam int unsigned CNT_W = $clog2(ID_W);

  logic [ID_W-1:0]  dvd;
  logic [DIV_W-1:0] r;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;

  assign trial = {r, dvd[ID_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign rem   = r[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      dvd  <= dividend;
      r    <= '0;
    end else if (busy) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, divisor}) begin
        r <= diff[DIV_W-1:0];
      end else begin
        r <= trial[DIV_W-1:0];
      end
      dvd <= dvd << 1;
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(ID_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/rtks_ctrl.sv */
// ----------------------------------------------------------------------------
// rtks_ctrl: sequencer of the ranked top-k selector
// Steps load, selection scans, spread computation and result emission.
// ----------------------------------------------------------------------------
module rtks_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cand_valid,
  input  logic           cand_last,
  output logic           cand_ready,
  input  rtks_pkg::sts_t sts,
  output rtks_pkg::cmd_t cmd
);
  import rtks_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_FETCH,
    S_START,
    S_MOD,
    S_EMIT,
    S_EMPTY,
    S_SHORT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign cand_ready = (state == S_LOAD);
  assign accept     = cand_valid && cand_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (cand_last) begin
            if (sts.want_zero) begin
              state_next = S_EMPTY;
            end else begin
              cmd.scan_init = 1'b1;
              state_next    = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.found) begin
          cmd.pick_commit = 1'b1;
          if (sts.pick_last) begin
            state_next = S_FETCH;
          end else begin
            cmd.scan_again = 1'b1;
            state_next     = S_SCAN;
          end
        end else begin
          state_next = S_SHORT;
        end
      end
      S_FETCH: begin
        state_next = S_START;
      end
      S_START: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MOD;
      end
      S_MOD: begin
        if (sts.mod_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_pick = 1'b1;
          if (sts.out_last) begin
            cmd.set_clear = 1'b1;
            state_next    = S_LOAD;
          end else begin
            state_next = S_FETCH;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          cmd.status_code = ST_EMPTY;
          cmd.set_clear   = 1'b1;
          state_next      = S_LOAD;
        end
      end
      S_SHORT: begin
        if (sts.out_free) begin
          cmd.emit_status = 1'b1;
          cmd.status_code = ST_SHORT;
          cmd.set_clear   = 1'b1;
          state_next      = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/rtks_dp.sv */
// ----------------------------------------------------------------------------
// rtks_dp: datapath of the ranked top-k selector
// Candidate memories, scan compare, pick list, remainder units, output word.
// ----------------------------------------------------------------------------
module rtks_dp #(
  parameter int unsigned MAX_CANDIDATES = 256,
  parameter int unsigned MAX_PICK       = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [rtks_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtks_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  input  logic [rtks_pkg::ID_W-1:0]       cand_id,
  input  logic [rtks_pkg::RANK_W-1:0]     cand_rank,
  input  rtks_pkg::cmd_t                  cmd,
  output rtks_pkg::sts_t                  sts,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [rtks_pkg::ID_W-1:0]       picked_id,
  output logic [rtks_pkg::VAL_W-1:0]      hunger_value,
  output logic [rtks_pkg::VAL_W-1:0]      threat_value,
  output logic [rtks_pkg::STATUS_W-1:0]   status,
  output logic                            last_result
);
  import rtks_pkg::*;

  localparam int unsigned AW  = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int unsigned FW  = $clog2(MAX_CANDIDATES + 1);
  localparam int unsigned PAW = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int unsigned CW  = $clog2(MAX_PICK + 1);

  // configuration
  logic [DC_W-1:0]  pick_target;
  logic [VAL_W-1:0] hunger_low;
  logic [VAL_W-1:0] hunger_high;
  logic [VAL_W-1:0] threat_low;
  logic [VAL_W-1:0] threat_high;

  // control state
  logic [FW-1:0]     fill;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     idx_d;
  logic              cmp_en;
  logic              found;
  logic              have_last;
  logic [CW-1:0]     pick_cnt;
  logic [CW-1:0]     oi;

  // payload state
  logic [ID_W-1:0]   best_id;
  logic [RANK_W-1:0] top_rank;
  logic [ID_W-1:0]   last_id;
  logic [ID_W-1:0]   cur_id;

  logic              full;
  logic              store_we;
  logic [CW-1:0]     want;
  logic [ID_W-1:0]   id_rd;
  logic [RANK_W-1:0] rank_rd;
  logic              excl_rd;
  logic              excl_now;
  logic              better;
  logic              excl_we;
  logic [AW-1:0]     excl_waddr;
  logic [ID_W-1:0]   pk_rd;
  logic [DIV_W-1:0]  hunger_div;
  logic [DIV_W-1:0]  threat_div;
  logic              hunger_busy;
  logic              threat_busy;
  logic [VAL_W-1:0]  hunger_rem;
  logic [VAL_W-1:0]  threat_rem;
  logic [VAL_W-1:0]  hunger_spread;
  logic [VAL_W-1:0]  threat_spread;

  assign full     = (fill == FW'(MAX_CANDIDATES));
  assign store_we = cmd.load && !full;
  assign want     = (32'(pick_target) > MAX_PICK) ? CW'(MAX_PICK) : CW'(pick_target);

  // candidate memories and per-entry exclusion bit
  rtks_ram #(.WIDTH(ID_W), .DEPTH(MAX_CANDIDATES)) u_id_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (fill[AW-1:0]),
    .wdata (cand_id),
    .raddr (idx),
    .rdata (id_rd)
  );

  rtks_ram #(.WIDTH(RANK_W), .DEPTH(MAX_CANDIDATES)) u_rank_ram (
    .clk   (clk),
    .we    (store_we),
    .waddr (fill[AW-1:0]),
    .wdata (cand_rank),
    .raddr (idx),
    .rdata (rank_rd)
  );

  // entry is excluded once its id matches a pick; mark it as the scan passes
  assign excl_now   = excl_rd || (have_last && (id_rd == last_id));
  assign excl_we    = store_we || cmp_en;
  assign excl_waddr = store_we ? fill[AW-1:0] : idx_d;

  rtks_ram #(.WIDTH(1), .DEPTH(MAX_CANDIDATES)) u_excl_ram (
    .clk   (clk),
    .we    (excl_we),
    .waddr (excl_waddr),
    .wdata (store_we ? 1'b0 : excl_now),
    .raddr (idx),
    .rdata (excl_rd)
  );

  assign better = !found || (rank_rd > top_rank) ||
                  ((rank_rd == top_rank) && (id_rd < best_id));

  rtks_ram #(.WIDTH(ID_W), .DEPTH(MAX_PICK)) u_pick_ram (
    .clk   (clk),
    .we    (cmd.pick_commit),
    .waddr (pick_cnt[PAW-1:0]),
    .wdata (best_id),
    .raddr (oi[PAW-1:0]),
    .rdata (pk_rd)
  );

  // spread moduli: high - low + 1, only used when high > low
  assign hunger_div = {1'b0, hunger_high} - {1'b0, hunger_low} + DIV_W'(1);
  assign threat_div = {1'b0, threat_high} - {1'b0, threat_low} + DIV_W'(1);

  rtks_mod u_hunger_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (pk_rd),
    .divisor  (hunger_div),
    .busy     (hunger_busy),
    .rem      (hunger_rem)
  );

  rtks_mod u_threat_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (pk_rd),
    .divisor  (threat_div),
    .busy     (threat_busy),
    .rem      (threat_rem)
  );

  assign hunger_spread = (hunger_high <= hunger_low) ? hunger_low : hunger_low + hunger_rem;
  assign threat_spread = (threat_high <= threat_low) ? threat_low : threat_low + threat_rem;

  assign sts.want_zero = (pick_target == '0);
  assign sts.scan_last = (FW'(idx) + FW'(1) == fill);
  assign sts.found     = found;
  assign sts.pick_last = (pick_cnt + CW'(1) == want);
  assign sts.mod_done  = !hunger_busy && !threat_busy;
  assign sts.out_free  = !res_valid || res_ready;
  assign sts.out_last  = (oi + CW'(1) == want);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pick_target <= '0;
      hunger_low  <= '0;
      hunger_high <= '0;
      threat_low  <= '0;
      threat_high <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DESIRED_COUNT: pick_target <= cfg_wr_data[DC_W-1:0];
        REG_HUNGER_LOW:    hunger_low  <= cfg_wr_data[VAL_W-1:0];
        REG_HUNGER_HIGH:   hunger_high <= cfg_wr_data[VAL_W-1:0];
        REG_THREAT_LOW:    threat_low  <= cfg_wr_data[VAL_W-1:0];
        REG_THREAT_HIGH:   threat_high <= cfg_wr_data[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // counters and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      idx       <= '0;
      idx_d     <= '0;
      cmp_en    <= 1'b0;
      found     <= 1'b0;
      have_last <= 1'b0;
      pick_cnt  <= '0;
      oi        <= '0;
    end else begin
      cmp_en <= cmd.scan_rd;
      idx_d  <= idx;
      if (store_we) begin
        fill <= fill + FW'(1);
      end
      if (cmd.set_clear) begin
        fill <= '0;
      end
      if (cmd.scan_rd) begin
        idx <= idx + AW'(1);
      end
      if (cmp_en && !excl_now && better) begin
        found <= 1'b1;
      end
      if (cmd.scan_init) begin
        idx       <= '0;
        found     <= 1'b0;
        have_last <= 1'b0;
        pick_cnt  <= '0;
        oi        <= '0;
      end
      if (cmd.pick_commit) begin
        have_last <= 1'b1;
        pick_cnt  <= pick_cnt + CW'(1);
      end
      if (cmd.scan_again) begin
        idx   <= '0;
        found <= 1'b0;
      end
      if (cmd.emit_pick) begin
        oi <= oi + CW'(1);
      end
    end
  end

  // best candidate of the running scan, last pick, id in flight
  always_ff @(posedge clk) begin
    if (cmp_en && !excl_now && better) begin
      best_id  <= id_rd;
      top_rank <= rank_rd;
    end
    if (cmd.pick_commit) begin
      last_id <= best_id;
    end
    if (cmd.mod_start) begin
      cur_id <= pk_rd;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_pick || cmd.emit_status) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_pick) begin
      picked_id    <= cur_id;
      hunger_value <= hunger_spread;
      threat_value <= threat_spread;
      status       <= ST_OK;
      last_result  <= sts.out_last;
    end else if (cmd.emit_status) begin
      picked_id    <= '0;
      hunger_value <= '0;
      threat_value <= '0;
      status       <= cmd.status_code;
      last_result  <= 1'b1;
    end
  end

endmodule
